>>> src/assert_macros.svh
// Assertion helpers for the fixed-point unit.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FXA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FXA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FXA_ASSERT_IMP(label, ante, cons, msg)
`define FXA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> src/fxa_pkg.sv
`timescale 1ns / 1ps

package fxa_pkg;

  localparam int ADD_W = 33;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    ACT_MUL  = 2'd0,
    ACT_DIV  = 2'd1,
    ACT_ROOT = 2'd2,
    ACT_MOD  = 2'd3
  } action_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_MODA = 7'b0010000,
    S_MODB = 7'b0100000,
    S_FIX  = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0] MUL_LAST  = 6'd31;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd47;
  localparam logic [CNT_W-1:0] ROOT_LAST = 6'd15;

  localparam logic [31:0] DIV0_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] DIV0_NEG = 32'h8000_0001;
  localparam logic [31:0] INT_MASK = 32'hFFFF_0000;
  localparam logic [31:0] ROOT_TOP = 32'h4000_0000;

endpackage

>>> src/fxa_addsub.sv
`timescale 1ns / 1ps

module fxa_addsub (
  input  logic [fxa_pkg::ADD_W-1:0] x,
  input  logic [fxa_pkg::ADD_W-1:0] y,
  input  logic                      sub,
  output logic [fxa_pkg::ADD_W:0]   sum    // top bit: carry out, set when x >= y on subtract
);
  import fxa_pkg::*;

  logic [ADD_W-1:0] y_op;

  assign y_op = sub ? ~y : y;
  assign sum  = {1'b0, x} + {1'b0, y_op} + {{ADD_W{1'b0}}, sub};

endmodule

>>> src/fixed_point_16_16_alu_core.sv
// Signed 16.16 arithmetic unit on one shared 33-bit add/subtract unit.
// Divide or modulo by zero and root of zero or below skip the iteration and go straight
// to the finish step. A new transaction is accepted only while the sequencer is idle,
// so transactions run one at a time through the 32 multiply, 48 divide and 16 root
// steps of the shared adder.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_point_16_16_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result
);
  import fxa_pkg::*;

  state_t           state_r, state_nxt;
  action_t          op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [32:0]      acc_r, acc_nxt;
  logic [31:0]      q_r, q_nxt;
  logic [31:0]      dvs_r, dvs_nxt;
  logic [31:0]      a_r, a_nxt;
  logic [31:0]      bmag_r, bmag_nxt;
  logic             bsgn_r, bsgn_nxt;
  logic             neg_r, neg_nxt;
  logic             byp_r, byp_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;

  logic [ADD_W-1:0] ux, uy;
  logic             usub;
  logic [ADD_W:0]   usum;

  logic [31:0]      in_a, in_b, amag, bmag;
  action_t          in_act;
  logic [31:0]      root_bit, mul_val, fix_val, mod_q, mod_mag;
  logic [32:0]      mul_pick;
  logic             div_bit, ge, out_ld, accept;

  fxa_addsub u_addsub (
    .x   (ux),
    .y   (uy),
    .sub (usub),
    .sum (usum)
  );

  assign in_a      = in_tdata[31:0];
  assign in_b      = in_tdata[63:32];
  assign in_act    = action_t'(in_tuser);
  assign amag      = in_a[31] ? (32'd0 - in_a) : in_a;
  assign bmag      = in_b[31] ? (32'd0 - in_b) : in_b;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_ld    = !out_valid_r || out_tready;

  assign root_bit = ROOT_TOP >> {cnt_r[3:0], 1'b0};
  assign mul_val  = {acc_r[15:0], q_r[31:16]};
  // dividend bits run out after 32 steps; the 16 fraction bits are zero
  assign div_bit  = ~cnt_r[5] & q_r[31];
  assign ge       = usum[ADD_W];
  assign mul_pick = q_r[0] ? usum[32:0] : acc_r;
  assign mod_q    = (neg_r ? usum[31:0] : q_r) & INT_MASK;
  assign mod_mag  = q_r[31] ? usum[31:0] : q_r;

  // operand steering for the shared unit
  always_comb begin
    ux   = '0;
    uy   = '0;
    usub = 1'b0;
    unique case (state_r)
      S_IDLE: begin
      end
      S_MUL: begin
        ux = {1'b0, acc_r[31:0]};
        uy = {1'b0, dvs_r};
      end
      S_DIV: begin
        ux   = {acc_r[31:0], div_bit};
        uy   = {1'b0, dvs_r};
        usub = 1'b1;
      end
      S_ROOT: begin
        ux   = acc_r;
        uy   = {1'b0, q_r | root_bit};
        usub = 1'b1;
      end
      S_MODA, S_MODB: begin
        uy   = {1'b0, q_r};
        usub = 1'b1;
      end
      S_FIX: begin
        unique case (op_r)
          ACT_MUL: begin
            uy   = {1'b0, mul_val};
            usub = 1'b1;
          end
          ACT_DIV: begin
            uy   = {1'b0, q_r};
            usub = 1'b1;
          end
          ACT_ROOT: begin
            ux = {1'b0, dvs_r};
            uy = {1'b0, q_r};
          end
          ACT_MOD: begin
            ux   = {1'b0, a_r};
            uy   = {1'b0, mul_val};
            usub = ~neg_r;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fix_val = q_r;
    if (!byp_r) begin
      unique case (op_r)
        ACT_MUL:  fix_val = neg_r ? usum[31:0] : mul_val;
        ACT_DIV:  fix_val = neg_r ? usum[31:0] : q_r;
        ACT_ROOT: fix_val = {1'b0, usum[31:1]};
        ACT_MOD:  fix_val = usum[31:0];
        default:  fix_val = q_r;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    dvs_nxt       = dvs_r;
    a_nxt         = a_r;
    bmag_nxt      = bmag_r;
    bsgn_nxt      = bsgn_r;
    neg_nxt       = neg_r;
    byp_nxt       = byp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_act;
          a_nxt    = in_a;
          bmag_nxt = bmag;
          bsgn_nxt = in_b[31];
          neg_nxt  = in_a[31] ^ in_b[31];
          cnt_nxt  = '0;
          acc_nxt  = '0;
          byp_nxt  = 1'b0;
          unique case (in_act)
            ACT_MUL: begin
              q_nxt     = bmag;
              dvs_nxt   = amag;
              state_nxt = S_MUL;
            end
            ACT_DIV, ACT_MOD: begin
              if (in_b == 32'd0) begin
                byp_nxt   = 1'b1;
                q_nxt     = (in_act == ACT_MOD) ? 32'd0 :
                            (in_a[31] ? DIV0_NEG : DIV0_POS);
                state_nxt = S_FIX;
              end else begin
                q_nxt     = amag;
                dvs_nxt   = bmag;
                state_nxt = S_DIV;
              end
            end
            ACT_ROOT: begin
              neg_nxt = 1'b0;
              q_nxt   = '0;
              if (in_a[31] || in_a == 32'd0) begin
                byp_nxt   = 1'b1;
                state_nxt = S_FIX;
              end else begin
                acc_nxt   = {1'b0, in_a};
                state_nxt = S_ROOT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        acc_nxt = {1'b0, mul_pick[32:1]};
        q_nxt   = {mul_pick[0], q_r[31:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_FIX;
        end
      end
      S_DIV: begin
        acc_nxt = ge ? usum[32:0] : {acc_r[31:0], div_bit};
        q_nxt   = {q_r[30:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = (op_r == ACT_MOD) ? S_MODA : S_FIX;
        end
      end
      S_ROOT: begin
        acc_nxt = ge ? usum[32:0] : acc_r;
        q_nxt   = ge ? ({1'b0, q_r[31:1]} | root_bit) : {1'b0, q_r[31:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          // refine: divide the radicand by the root scaled to 16.16
          dvs_nxt   = {q_nxt[23:0], 8'd0};
          q_nxt     = a_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_MODA: begin
        q_nxt     = mod_q;
        state_nxt = S_MODB;
      end
      S_MODB: begin
        dvs_nxt   = mod_mag;
        q_nxt     = bmag_r;
        neg_nxt   = q_r[31] ^ bsgn_r;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_FIX: begin
        if (out_ld) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = fix_val;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    dvs_r      <= dvs_nxt;
    a_r        <= a_nxt;
    bmag_r     <= bmag_nxt;
    bsgn_r     <= bsgn_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FXA_ASSERT_IMP(a_div_rem_bound, state_r == S_DIV, acc_r < {1'b0, dvs_r},
                  "remainder not below divisor")
  `FXA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= DIV_LAST + 6'd1, "step counter out of range")
  `FXA_ASSERT_NXT(a_accept_busy, accept, state_r != S_IDLE, "sequencer idle after accept")
  `FXA_ASSERT_NXT(a_root_width, state_r == S_ROOT && cnt_r == ROOT_LAST,
                  dvs_r[31:24] == 8'd0, "root wider than 16 bits")
  `FXA_ASSERT_IMP(a_out_from_fix, $rose(out_valid_r), $past(state_r) == S_FIX,
                  "result without finish step")

endmodule
